FILE: hw/rtl/bms_pkg.sv
// bms_pkg: shared types, codes and constants for the beep and morse sequencer
// no dependencies; used by every module of the block by scoped names
package bms_pkg;

    // pattern store geometry
    localparam int SYMBOL_SLOTS = 64;
    localparam int SLOT_W       = $clog2(SYMBOL_SLOTS);
    localparam int POS_W        = $clog2(SYMBOL_SLOTS + 1);

    // field widths
    localparam int OP_W    = 2;
    localparam int BEEP_W  = 32;
    localparam int IDX_W   = 6;
    localparam int CHAR_W  = 8;
    localparam int DIT_W   = 10;
    localparam int ELEM_W  = 12;

    // dit length after reset
    localparam logic [DIT_W-1:0] DIT_RESET = DIT_W'(100);

    // operations
    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_BEEP = 2'd1;
    localparam logic [OP_W-1:0] OP_SYM  = 2'd2;

    // character bytes accepted as symbols
    localparam logic [CHAR_W-1:0] CHAR_DIT   = 8'd46;
    localparam logic [CHAR_W-1:0] CHAR_DAH   = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

    // stored symbol codes
    localparam logic [1:0] SYM_DIT   = 2'd0;
    localparam logic [1:0] SYM_DAH   = 2'd1;
    localparam logic [1:0] SYM_SPACE = 2'd2;

    // one input item
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BEEP_W-1:0] beep_length;
        logic [IDX_W-1:0]  symbol_index;
        logic [CHAR_W-1:0] symbol_code;
    } t_item;

    // one result item, piezo_pulse in the lowest bit
    typedef struct packed {
        logic status;
        logic morse_done;
        logic beep_done;
        logic piezo_pulse;
    } t_result;

    // sequencer status seen by the top level
    typedef struct packed {
        logic beep_active;
        logic play_idle;
    } t_core_stat;

endpackage

FILE: hw/rtl/bms_in_skid.sv
// bms_in_skid: input register with a skid stage for the item stream
// depends on bms_pkg (t_item)
module bms_in_skid (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bms_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_take,
    output bms_pkg::t_item o_item
);

    logic           r_valid;
    logic           r_sk_valid;
    bms_pkg::t_item r_item;
    bms_pkg::t_item r_sk_item;
    logic           w_acc;

    // ready only depends on the skid stage being empty
    assign o_ready = !r_sk_valid;
    assign w_acc   = i_valid && !r_sk_valid;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (!r_valid || i_take) begin
            if (r_sk_valid) begin
                r_valid    <= 1'b1;
                r_sk_valid <= 1'b0;
            end else begin
                r_valid <= w_acc;
            end
        end else if (w_acc) begin
            r_sk_valid <= 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (!r_valid || i_take) begin
            if (r_sk_valid) begin
                r_item <= r_sk_item;
            end else if (w_acc) begin
                r_item <= i_item;
            end
        end else if (w_acc) begin
            r_sk_item <= i_item;
        end
    end

endmodule

FILE: hw/rtl/bms_core.sv
// bms_core: sequencer state, pattern store and per-item update logic
// depends on bms_pkg (codes, t_item, t_result, t_core_stat)
module bms_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  bms_pkg::t_item              i_item,
    input  logic [bms_pkg::DIT_W-1:0]   i_dit,
    output bms_pkg::t_result            o_result,
    output bms_pkg::t_core_stat         o_stat
);

    logic [bms_pkg::BEEP_W-1:0]         r_beep, n_beep;
    logic [bms_pkg::ELEM_W-1:0]         r_elem, n_elem;
    logic                               r_tone, n_tone;
    logic [bms_pkg::POS_W-1:0]          r_pos, n_pos;
    logic [1:0]                         r_store [bms_pkg::SYMBOL_SLOTS];
    logic [1:0]                         r_rd;
    logic [bms_pkg::ELEM_W-1:0]         w_dit_e;
    logic [bms_pkg::ELEM_W-1:0]         w_dah_e;
    logic [bms_pkg::ELEM_W-1:0]         w_dec;
    logic [bms_pkg::POS_W-1:0]          w_pos_inc;
    logic [1:0]                         w_enc;
    logic                               w_sym_ok;
    logic                               w_we;
    logic [bms_pkg::SLOT_W-1:0]         w_wa;
    logic [bms_pkg::SLOT_W-1:0]         w_ra;
    bms_pkg::t_result                   w_res;

    // element lengths from the dit length
    assign w_dit_e   = bms_pkg::ELEM_W'(i_dit);
    assign w_dah_e   = {w_dit_e[bms_pkg::ELEM_W-2:0], 1'b0} + w_dit_e;
    assign w_dec     = r_elem - 1'b1;
    assign w_pos_inc = r_pos + 1'b1;

    // symbol byte decode
    always_comb begin
        w_enc    = bms_pkg::SYM_DIT;
        w_sym_ok = 1'b1;
        case (i_item.symbol_code)
            bms_pkg::CHAR_DIT:   w_enc = bms_pkg::SYM_DIT;
            bms_pkg::CHAR_DAH:   w_enc = bms_pkg::SYM_DAH;
            bms_pkg::CHAR_SPACE: w_enc = bms_pkg::SYM_SPACE;
            default:             w_sym_ok = 1'b0;
        endcase
    end

    // next state and result for the item being processed
    always_comb begin
        n_beep = r_beep;
        n_elem = r_elem;
        n_tone = r_tone;
        n_pos  = r_pos;
        w_res  = '0;
        if (i_go) begin
            case (i_item.operation)
                bms_pkg::OP_TICK: begin
                    if (r_beep != '0) begin
                        n_beep            = r_beep - 1'b1;
                        w_res.piezo_pulse = 1'b1;
                        w_res.beep_done   = (r_beep == bms_pkg::BEEP_W'(1));
                    end else if (r_elem != '0) begin
                        n_elem = w_dec;
                        if (r_tone) begin
                            w_res.piezo_pulse = 1'b1;
                            if (w_dec == '0) begin
                                n_tone = 1'b0;
                                n_elem = w_dit_e;
                            end
                        end
                    end
                    // fetch the next slot once the element has run out
                    if (r_pos < bms_pkg::POS_W'(bms_pkg::SYMBOL_SLOTS) && n_elem == '0) begin
                        case (r_rd)
                            bms_pkg::SYM_DIT: begin
                                n_tone = 1'b1;
                                n_elem = w_dit_e;
                            end
                            bms_pkg::SYM_DAH: begin
                                n_tone = 1'b1;
                                n_elem = w_dah_e;
                            end
                            default: begin
                                n_tone = 1'b0;
                                n_elem = w_dit_e;
                            end
                        endcase
                        n_pos            = w_pos_inc;
                        w_res.morse_done =
                            (w_pos_inc == bms_pkg::POS_W'(bms_pkg::SYMBOL_SLOTS));
                    end
                end
                bms_pkg::OP_BEEP: begin
                    n_pos  = bms_pkg::POS_W'(bms_pkg::SYMBOL_SLOTS);
                    n_elem = '0;
                    n_tone = 1'b0;
                    n_beep = i_item.beep_length;
                end
                bms_pkg::OP_SYM: begin
                    // slot 0 restarts playback even for a rejected symbol
                    if (i_item.symbol_index == '0) begin
                        n_beep = '0;
                        n_pos  = '0;
                        n_elem = '0;
                        n_tone = 1'b0;
                    end
                    w_res.status = !w_sym_ok;
                end
                default: ;
            endcase
        end
    end

    // store write port
    assign w_we = i_go && (i_item.operation == bms_pkg::OP_SYM) && w_sym_ok &&
                  (bms_pkg::POS_W'(i_item.symbol_index) <
                   bms_pkg::POS_W'(bms_pkg::SYMBOL_SLOTS));
    assign w_wa = bms_pkg::SLOT_W'(i_item.symbol_index);
    // prefetch the slot at the next play position
    assign w_ra = n_pos[bms_pkg::SLOT_W-1:0];

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beep <= '0;
            r_elem <= '0;
            r_tone <= 1'b0;
            r_pos  <= bms_pkg::POS_W'(bms_pkg::SYMBOL_SLOTS);
        end else begin
            r_beep <= n_beep;
            r_elem <= n_elem;
            r_tone <= n_tone;
            r_pos  <= n_pos;
        end
    end

    // pattern store with write-through on the registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_wa] <= w_enc;
        end
        if (w_we && w_wa == w_ra) begin
            r_rd <= w_enc;
        end else begin
            r_rd <= r_store[w_ra];
        end
    end

    assign o_result           = w_res;
    assign o_stat.beep_active = (r_beep != '0);
    assign o_stat.play_idle   = (r_pos == bms_pkg::POS_W'(bms_pkg::SYMBOL_SLOTS));

endmodule

FILE: hw/rtl/beep_and_morse_sequencer.sv
// beep_and_morse_sequencer: top level, dit length register and result register
// depends on bms_pkg, bms_in_skid and bms_core
//
//  channel  | direction | beat moves
//  ---------+-----------+------------------------------------------------
//  s_axis   | in        | tick, beep start or symbol write (one item)
//  m_axis   | out       | one result per item
//  cfg      | in        | dit length in ticks (10 bits)
//
// one item per cycle sustained while m_axis does not stall; an input beat
// passes through the input register and the state update to the result
// register. reset is synchronous, active low; the pattern store keeps no
// reset and is needed only for slots already written. the input skid stage
// keeps s_axis_tready registered while m_axis stalls.
module beep_and_morse_sequencer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // beep_length[31:0], symbol_index[37:32], symbol_code[45:38], zero pad
    input  logic [47:0]               s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]                s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // piezo_pulse[0], beep_done[1], morse_done[2], status[3], zero pad
    output logic [7:0]                m_axis_tdata,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [bms_pkg::DIT_W-1:0] i_cfg_data
);

    bms_pkg::t_item      w_in_item;
    bms_pkg::t_item      w_item;
    bms_pkg::t_result    w_res;
    bms_pkg::t_result    r_out;
    bms_pkg::t_core_stat w_stat;
    logic                w_valid;
    logic                w_take;
    logic                w_go;
    logic                r_out_valid;
    logic [bms_pkg::DIT_W-1:0] r_dit;

    // unpack the input beat
    assign w_in_item.operation    = s_axis_tuser;
    assign w_in_item.beep_length  = s_axis_tdata[31:0];
    assign w_in_item.symbol_index = s_axis_tdata[37:32];
    assign w_in_item.symbol_code  = s_axis_tdata[45:38];

    bms_in_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .o_valid (w_valid),
        .i_take  (w_take),
        .o_item  (w_item)
    );

    // result register frees up when empty or drained this cycle
    assign w_take = !r_out_valid || m_axis_tready;
    assign w_go   = w_valid && w_take;

    bms_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_go),
        .i_item   (w_item),
        .i_dit    (r_dit),
        .o_result (w_res),
        .o_stat   (w_stat)
    );

    // dit length register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dit <= bms_pkg::DIT_RESET;
        end else if (i_cfg_valid) begin
            r_dit <= i_cfg_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= w_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out};

    // a running beep always leaves morse playback idle
    a_beep_stops_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.beep_active |-> w_stat.play_idle)
        else $error("beep running while morse playback active");

    // fetching the last slot leaves playback idle
    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go && w_res.morse_done |=> w_stat.play_idle)
        else $error("playback not idle after last slot");

    // a full skid stage implies the input register holds an item
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_valid)
        else $error("skid stage full with empty input register");

    // an item in the input register reaches the result register when it frees up
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid && w_take |=> r_out_valid)
        else $error("processed item missing from result register");

endmodule

FILE: sim/tb_beep_and_morse_sequencer.sv
// tb_beep_and_morse_sequencer: self-checking bench for the piezo keyer, with directed and
// random item streams, random stalls on both streams and dit length changes between phases
// depends on bms_pkg and beep_and_morse_sequencer
module tb_beep_and_morse_sequencer;
    import bms_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int DAH_DITS      = 3;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_PCT      = 31;
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 100000;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [47:0]       s_axis_tdata;
    logic [1:0]        s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [7:0]        m_axis_tdata;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [DIT_W-1:0]  i_cfg_data;

    // no random idling on either stream while set
    bit calm;
    int sent_items;

    beep_and_morse_sequencer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // keyer state mirror and queue of awaited result beats
    class keyer_scoreboard;
        logic [DIT_W-1:0]  dit_len;
        logic [BEEP_W-1:0] beep_left;
        logic [ELEM_W-1:0] elem_left;
        bit                tone;
        logic [POS_W-1:0]  play_pos;
        logic [1:0]        slot_sym [SYMBOL_SLOTS];
        bit                slot_written [SYMBOL_SLOTS];
        t_result           awaited_results [$];
        int                errors;

        function new();
            dit_len   = DIT_RESET;
            beep_left = '0;
            elem_left = '0;
            tone      = 1'b0;
            play_pos  = POS_W'(SYMBOL_SLOTS);
            errors    = 0;
            foreach (slot_written[i]) begin
                slot_written[i] = 1'b0;
                slot_sym[i]     = SYM_DIT;
            end
        endfunction

        function void set_dit(input logic [DIT_W-1:0] v);
            dit_len = v;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // slot that the next tick would fetch, if it fetches one
        function logic [SLOT_W-1:0] next_slot();
            return play_pos[SLOT_W-1:0];
        endfunction

        // true when a tick now would read a slot never written
        function bit tick_needs_slot();
            logic [ELEM_W-1:0] e;
            e = elem_left;
            if (beep_left == 0 && e != 0) begin
                e = e - 1'b1;
                if (tone && e == 0) e = ELEM_W'(dit_len);
            end
            return (play_pos < SYMBOL_SLOTS) && (e == 0) && !slot_written[next_slot()];
        endfunction

        // keyer behaviour for one input beat
        function t_result keyer_step(input t_item it);
            t_result r;
            bit      valid;
            logic [1:0] sym;
            r = '0;
            case (it.operation)
                OP_TICK: begin
                    // running beep wins over the morse element
                    if (beep_left != 0) begin
                        beep_left     = beep_left - 1'b1;
                        r.piezo_pulse = 1'b1;
                        if (beep_left == 0) r.beep_done = 1'b1;
                    end else if (elem_left != 0) begin
                        elem_left = elem_left - 1'b1;
                        if (tone) begin
                            r.piezo_pulse = 1'b1;
                            if (elem_left == 0) begin
                                tone      = 1'b0;
                                elem_left = ELEM_W'(dit_len);
                            end
                        end
                    end
                    // fetch the next slot once the element has run out
                    if (play_pos < SYMBOL_SLOTS && elem_left == 0) begin
                        case (slot_sym[next_slot()])
                            SYM_DIT: begin
                                tone      = 1'b1;
                                elem_left = ELEM_W'(dit_len);
                            end
                            SYM_DAH: begin
                                tone      = 1'b1;
                                elem_left = ELEM_W'(dit_len * DAH_DITS);
                            end
                            default: begin
                                tone      = 1'b0;
                                elem_left = ELEM_W'(dit_len);
                            end
                        endcase
                        play_pos = play_pos + 1'b1;
                        if (play_pos == SYMBOL_SLOTS) r.morse_done = 1'b1;
                    end
                end
                OP_BEEP: begin
                    play_pos  = POS_W'(SYMBOL_SLOTS);
                    elem_left = '0;
                    tone      = 1'b0;
                    beep_left = it.beep_length;
                end
                OP_SYM: begin
                    valid = 1'b1;
                    sym   = SYM_DIT;
                    case (it.symbol_code)
                        CHAR_DIT:   sym = SYM_DIT;
                        CHAR_DAH:   sym = SYM_DAH;
                        CHAR_SPACE: sym = SYM_SPACE;
                        default:    valid = 1'b0;
                    endcase
                    // slot zero restarts playback even for a rejected code
                    if (it.symbol_index == 0) begin
                        beep_left = '0;
                        play_pos  = '0;
                        elem_left = '0;
                        tone      = 1'b0;
                    end
                    if (valid) begin
                        slot_sym[it.symbol_index]     = sym;
                        slot_written[it.symbol_index] = 1'b1;
                    end else begin
                        r.status = 1'b1;
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_item(input t_item it);
            awaited_results.push_back(keyer_step(it));
        endfunction

        function void check_result(input logic [7:0] beat);
            t_result got;
            t_result exp;
            got = t_result'(beat[3:0]);
            if (awaited_results.size() == 0) begin
                $error("result beat %h with no expectation waiting", beat);
                errors++;
                return;
            end
            exp = awaited_results.pop_front();
            if (got.piezo_pulse !== exp.piezo_pulse) begin
                $error("piezo_pulse: expected %0d, got %0d", exp.piezo_pulse, got.piezo_pulse);
                errors++;
            end
            if (got.beep_done !== exp.beep_done) begin
                $error("beep_done: expected %0d, got %0d", exp.beep_done, got.beep_done);
                errors++;
            end
            if (got.morse_done !== exp.morse_done) begin
                $error("morse_done: expected %0d, got %0d", exp.morse_done, got.morse_done);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (beat[7:4] !== 4'h0) begin
                $error("pad: expected 0, got %h", beat[7:4]);
                errors++;
            end
        endfunction
    endclass

    keyer_scoreboard sb = new();

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #8000000;
        $display("beep_and_morse_sequencer regression: fail");
        $finish;
    end

    // result side: random stalls, one long hold-off, checking of every beat
    initial begin
        int results_seen;
        int hold_left;
        bit hold_done;
        results_seen  = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
                sb.check_result(m_axis_tdata);
                results_seen++;
            end
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done     = 1'b1;
                hold_left     = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic t_item make_item(input logic [OP_W-1:0] op, input logic [BEEP_W-1:0] len,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [CHAR_W-1:0] code);
        t_item it;
        it.operation    = op;
        it.beep_length  = len;
        it.symbol_index = idx;
        it.symbol_code  = code;
        return it;
    endfunction

    function automatic logic [CHAR_W-1:0] good_code();
        case ($urandom_range(0, 2))
            0:       return CHAR_DIT;
            1:       return CHAR_DAH;
            default: return CHAR_SPACE;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] bad_code();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom_range(0, 255));
        while (c == CHAR_DIT || c == CHAR_DAH || c == CHAR_SPACE);
        return c;
    endfunction

    // one input beat, with random idle cycles ahead of it unless calm is set
    task automatic offer_beat(input t_item it);
        if (!calm) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, it.symbol_code, it.symbol_index, it.beep_length};
        s_axis_tuser  <= it.operation;
        do @(posedge i_clk);
        while (s_axis_tready !== 1'b1);
        sb.note_item(it);
        if (it.operation != OP_UNUSED) sent_items++;
    endtask

    // a tick never fetches an unwritten slot: fill the slot first
    task automatic send_item(input t_item it);
        if (it.operation == OP_TICK && sb.tick_needs_slot())
            offer_beat(make_item(OP_SYM, $urandom, sb.next_slot(), good_code()));
        offer_beat(it);
    endtask

    task automatic send_tick();
        send_item(make_item(OP_TICK, $urandom, IDX_W'($urandom_range(0, 63)),
                            CHAR_W'($urandom_range(0, 255))));
    endtask

    // dit length change once the block has drained
    task automatic write_dit(input logic [DIT_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        sb.set_dit(v);
    endtask

    // random traffic: mostly playback runs, then beeps, then noise
    task automatic random_phase(input int quota);
        int start_count;
        int kind;
        int n;
        int r;
        logic [BEEP_W-1:0] len;
        start_count = sent_items;
        while (sent_items - start_count < quota) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                // restart playback and let it run, with a few writes on the way
                send_item(make_item(OP_SYM, $urandom, '0,
                                    ($urandom_range(0, 9) == 0) ? bad_code() : good_code()));
                n = $urandom_range(30, 320);
                for (int k = 0; k < n && sent_items - start_count < quota; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 4)
                        send_item(make_item(OP_SYM, $urandom, IDX_W'($urandom_range(1, 63)),
                                            good_code()));
                    else if (r < 6)
                        send_item(make_item(OP_SYM, $urandom, IDX_W'($urandom_range(1, 63)),
                                            bad_code()));
                    else if (r < 7)
                        send_item(make_item(OP_UNUSED, $urandom, IDX_W'($urandom_range(0, 63)),
                                            CHAR_W'($urandom_range(0, 255))));
                    else
                        send_tick();
                end
            end else if (kind < 85) begin
                // beep, ticks through it, sometimes cut short by a restart
                len = ($urandom_range(0, 9) == 0) ? BEEP_W'($urandom)
                                                  : BEEP_W'($urandom_range(0, 24));
                send_item(make_item(OP_BEEP, len, IDX_W'($urandom_range(0, 63)),
                                    CHAR_W'($urandom_range(0, 255))));
                n = $urandom_range(0, 30);
                repeat (n) send_tick();
                if ($urandom_range(0, 99) < 15)
                    send_item(make_item(OP_SYM, $urandom, '0, good_code()));
            end else begin
                // burst of unconstrained beats
                n = $urandom_range(1, 10);
                repeat (n)
                    send_item(make_item(OP_W'($urandom_range(0, 3)), $urandom,
                                        IDX_W'($urandom_range(0, 63)),
                                        ($urandom_range(0, 1) == 1) ? good_code()
                                            : CHAR_W'($urandom_range(0, 255))));
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        int drain;
        calm          = 1'b0;
        sent_items    = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset dit length
        send_item(make_item(OP_UNUSED, '1, '1, '1));
        send_item(make_item(OP_TICK, '0, '0, '0));
        send_item(make_item(OP_SYM, '1, '1, 8'hFF));
        send_item(make_item(OP_SYM, '0, 6'd5, 8'h00));
        send_item(make_item(OP_SYM, '0, '1, CHAR_DIT));
        send_item(make_item(OP_SYM, '0, 6'd1, CHAR_DAH));
        send_item(make_item(OP_SYM, '0, 6'd2, CHAR_SPACE));
        send_item(make_item(OP_BEEP, '0, '0, '0));
        send_tick();
        send_item(make_item(OP_BEEP, 32'd2, '0, '0));
        repeat (3) send_tick();
        send_item(make_item(OP_BEEP, '1, '0, '0));
        repeat (2) send_tick();
        // restart cancels the beep; first fetch is a dah
        send_item(make_item(OP_SYM, '0, '0, CHAR_DAH));
        repeat (2) send_tick();
        // rejected code on slot zero still restarts
        send_item(make_item(OP_SYM, '0, '0, 8'h2F));
        send_tick();
        // beep stops playback
        send_item(make_item(OP_BEEP, 32'd1, '0, '0));
        repeat (2) send_tick();

        // random phases over a range of dit lengths
        write_dit(10'd1);
        random_phase(280);
        write_dit(10'd0);
        random_phase(280);
        write_dit(10'd1023);
        random_phase(120);
        write_dit(10'd2);
        calm = 1'b1;
        random_phase(280);
        calm = 1'b0;
        write_dit(10'd3);
        random_phase(280);
        write_dit(DIT_W'($urandom_range(4, 9)));
        random_phase(280);
        write_dit(10'd1);
        random_phase(280);

        // drain
        s_axis_tvalid <= 1'b0;
        drain = 0;
        while (sb.pending() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("beep_and_morse_sequencer regression: pass");
        end else begin
            $display("beep_and_morse_sequencer regression: fail");
        end
        $finish;
    end

endmodule
